// ===== rtl/lgk_pkg.sv =====
// lgk_pkg: shared constants, codes and types for the lattice gas move core.
// No dependencies; imported by lgk_row_tally, the move core and the testbench.
`timescale 1ns / 1ps

package lgk_pkg;

    localparam int SIDE_X_DEF        = 64;
    localparam int SIDE_Y_DEF        = 64;
    localparam int MAX_PARTICLES_DEF = 1024;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_RISE_TWO  = 2'd0;
    localparam logic [1:0] REG_RISE_FOUR = 2'd1;
    localparam logic [1:0] REG_RISE_SIX  = 2'd2;

    localparam logic [31:0] RISE_TWO_RST  = 32'd581260615;
    localparam logic [31:0] RISE_FOUR_RST = 32'd78665070;
    localparam logic [31:0] RISE_SIX_RST  = 32'd10646159;

    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_MOVE  = 1'b1;

    localparam logic [1:0] DIR_XP = 2'd0;
    localparam logic [1:0] DIR_XM = 2'd1;
    localparam logic [1:0] DIR_YP = 2'd2;
    localparam logic [1:0] DIR_YM = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_REJECT   = 2'd1;
    localparam logic [1:0] STAT_OCCUPIED = 2'd2;
    localparam logic [1:0] STAT_INVALID  = 2'd3;

    // row scan steps: old site row, row below, row above, then same for target
    localparam logic [2:0] STEP_O_ROW = 3'd0;
    localparam logic [2:0] STEP_O_LO  = 3'd1;
    localparam logic [2:0] STEP_O_HI  = 3'd2;
    localparam logic [2:0] STEP_T_ROW = 3'd3;
    localparam logic [2:0] STEP_T_LO  = 3'd4;
    localparam logic [2:0] STEP_T_HI  = 3'd5;

    localparam logic signed [14:0] E_SUM_MAX = 15'sd8191;
    localparam logic signed [14:0] E_SUM_MIN = -15'sd8192;

    typedef struct packed {
        logic [1:0] cnt;
        logic       ctr;
    } tally_t;

    function automatic logic signed [13:0] sat_add(
        input logic signed [13:0] e,
        input logic signed [4:0]  d
    );
        logic signed [14:0] s;
        s = 15'(e) + 15'(d);
        if (s > E_SUM_MAX)
        begin
            s = E_SUM_MAX;
        end
        else if (s < E_SUM_MIN)
        begin
            s = E_SUM_MIN;
        end
        return 14'(s);
    endfunction

endpackage

// ===== rtl/lgk_ram.sv =====
// lgk_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the occupancy rows and the particle list.
`timescale 1ns / 1ps

module lgk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lgk_row_tally.sv =====
// lgk_row_tally: shared neighbor counter, picks bits around a column of one row.
// Depends on lgk_pkg (tally_t).
`timescale 1ns / 1ps

module lgk_row_tally
    import lgk_pkg::*;
#(
    parameter int SIDE_Y = SIDE_Y_DEF
) (
    input  logic [SIDE_Y-1:0]         row,
    input  logic [$clog2(SIDE_Y)-1:0] col,
    input  logic                      side_mode,
    output tally_t                    tally
);

    localparam int YW = $clog2(SIDE_Y);

    logic [YW-1:0] col_lo;
    logic [YW-1:0] col_hi;

    always_comb
    begin
        col_lo = (col == '0) ? YW'(SIDE_Y - 1) : col - YW'(1);
        col_hi = (col == YW'(SIDE_Y - 1)) ? '0 : col + YW'(1);
        tally.ctr = row[col];
        if (side_mode)
        begin
            tally.cnt = 2'(row[col_lo]) + 2'(row[col_hi]);
        end
        else
        begin
            tally.cnt = 2'(row[col]);
        end
    end

endmodule

// ===== rtl/lattice_gas_kawasaki_move_core.sv =====
// Lattice gas move core: 2D torus, Kawasaki hops, Metropolis acceptance.
// Depends on lgk_pkg, lgk_ram (occupancy rows, particle list), lgk_row_tally.
`timescale 1ns / 1ps

// Occupancy is held as one memory row per lattice column (SIDE_Y bits each) with a
// per-row valid bit, so reset takes effect at once with no clearing pass. Each
// word is handled alone; in_ready is low while it is worked on. The occupancy
// memory has one read port and delivers one row per cycle: a move reads six rows
// (a second row write follows when the hop crosses rows), and a place reads three
// rows. The result sits in an output register, so the next word is accepted while
// it waits. Thresholds are written over the APB port at 0x0, 0x4 and 0x8.

module lattice_gas_kawasaki_move_core
    import lgk_pkg::*;
#(
    parameter int SIDE_X        = SIDE_X_DEF,
    parameter int SIDE_Y        = SIDE_Y_DEF,
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [5:0]          site_x,
    input  logic [5:0]          site_y,
    input  logic [9:0]          particle_index,
    input  logic [1:0]          direction,
    input  logic [31:0]         random_value,

    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output logic signed [13:0]  energy,
    output logic [5:0]          pos_x,
    output logic [5:0]          pos_y
);

    localparam int XW = $clog2(SIDE_X);
    localparam int YW = $clog2(SIDE_Y);
    localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_SCAN  = 6'b000100,
        S_EVAL  = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    function automatic logic [XW-1:0] dec_x(input logic [XW-1:0] v);
        return (v == '0) ? XW'(SIDE_X - 1) : v - XW'(1);
    endfunction

    function automatic logic [XW-1:0] inc_x(input logic [XW-1:0] v);
        return (v == XW'(SIDE_X - 1)) ? '0 : v + XW'(1);
    endfunction

    function automatic logic [YW-1:0] dec_y(input logic [YW-1:0] v);
        return (v == '0) ? YW'(SIDE_Y - 1) : v - YW'(1);
    endfunction

    function automatic logic [YW-1:0] inc_y(input logic [YW-1:0] v);
        return (v == YW'(SIDE_Y - 1)) ? '0 : v + YW'(1);
    endfunction

    function automatic logic [SIDE_Y-1:0] col_bit(input logic [YW-1:0] c);
        logic [SIDE_Y-1:0] v;
        v    = '0;
        v[c] = 1'b1;
        return v;
    endfunction

    // control state
    state_t                state_reg, state_next;
    logic [2:0]            rd_step_reg, rd_step_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [SIDE_X-1:0]     rv_reg, rv_next;
    logic [CW-1:0]         count_reg, count_next;
    logic signed [13:0]    energy_reg, energy_next;
    logic [31:0]           thr_two_reg, thr_two_next;
    logic [31:0]           thr_four_reg, thr_four_next;
    logic [31:0]           thr_six_reg, thr_six_next;
    logic                  out_valid_reg, out_valid_next;

    // working data
    logic                  func_reg, func_next;
    logic [PW-1:0]         idx_reg, idx_next;
    logic [1:0]            dir_reg, dir_next;
    logic [31:0]           rnd_reg, rnd_next;
    logic [XW-1:0]         ox_reg, ox_next;
    logic [YW-1:0]         oy_reg, oy_next;
    logic [XW-1:0]         tx_reg, tx_next;
    logic [YW-1:0]         ty_reg, ty_next;
    logic [2:0]            pend_step_reg, pend_step_next;
    logic                  pend_rv_reg, pend_rv_next;
    logic [2:0]            n_reg, n_next;
    logic [2:0]            m_reg, m_next;
    logic                  tocc_reg, tocc_next;
    logic [SIDE_Y-1:0]     row_o_reg, row_o_next;
    logic [SIDE_Y-1:0]     row_t_reg, row_t_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [5:0]            res_x_reg, res_x_next;
    logic [5:0]            res_y_reg, res_y_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic signed [13:0]    out_energy_reg, out_energy_next;
    logic [5:0]            out_x_reg, out_x_next;
    logic [5:0]            out_y_reg, out_y_next;

    // memory ports
    logic                  occ_we;
    logic [XW-1:0]         occ_waddr;
    logic [SIDE_Y-1:0]     occ_wdata;
    logic                  occ_re;
    logic [XW-1:0]         occ_raddr;
    logic [SIDE_Y-1:0]     occ_rdata;
    logic                  pos_we;
    logic [PW-1:0]         pos_waddr;
    logic [XW+YW-1:0]      pos_wdata;
    logic                  pos_re;
    logic [PW-1:0]         pos_raddr;
    logic [XW+YW-1:0]      pos_rdata;

    logic [SIDE_Y-1:0]     occ_row;
    logic [YW-1:0]         tally_col;
    logic                  tally_side;
    tally_t                tally;

    logic                  cfg_wr;
    logic [XW-1:0]         row_base;
    logic signed [4:0]     d_move;
    logic signed [4:0]     de_move;
    logic signed [4:0]     de_place;
    logic [31:0]           thr_sel;
    logic                  accept;
    logic                  same_row;

    lgk_ram #(
        .WIDTH (SIDE_Y),
        .DEPTH (SIDE_X)
    ) u_occ_ram (
        .clk   (clk),
        .we    (occ_we),
        .waddr (occ_waddr),
        .wdata (occ_wdata),
        .re    (occ_re),
        .raddr (occ_raddr),
        .rdata (occ_rdata)
    );

    lgk_ram #(
        .WIDTH (XW + YW),
        .DEPTH (MAX_PARTICLES)
    ) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    lgk_row_tally #(
        .SIDE_Y (SIDE_Y)
    ) u_tally (
        .row       (occ_row),
        .col       (tally_col),
        .side_mode (tally_side),
        .tally     (tally)
    );

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign energy    = out_energy_reg;
    assign pos_x     = out_x_reg;
    assign pos_y     = out_y_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_RISE_TWO:  prdata = thr_two_reg;
            REG_RISE_FOUR: prdata = thr_four_reg;
            REG_RISE_SIX:  prdata = thr_six_reg;
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        thr_two_next  = thr_two_reg;
        thr_four_next = thr_four_reg;
        thr_six_next  = thr_six_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_RISE_TWO:  thr_two_next  = pwdata;
                REG_RISE_FOUR: thr_four_next = pwdata;
                REG_RISE_SIX:  thr_six_next  = pwdata;
                default:       ;
            endcase
        end
    end

    // scan datapath
    assign occ_row    = pend_rv_reg ? occ_rdata : '0;
    assign tally_col  = (pend_step_reg < STEP_T_ROW) ? oy_reg : ty_reg;
    assign tally_side = (pend_step_reg == STEP_O_ROW) || (pend_step_reg == STEP_T_ROW);
    assign row_base   = (rd_step_reg < STEP_T_ROW) ? ox_reg : tx_reg;

    always_comb
    begin
        case (rd_step_reg)
            STEP_O_LO, STEP_T_LO: occ_raddr = dec_x(row_base);
            STEP_O_HI, STEP_T_HI: occ_raddr = inc_x(row_base);
            default:              occ_raddr = row_base;
        endcase
    end

    // energy change and Metropolis test
    assign d_move   = $signed({2'b00, n_reg}) + 5'sd1 - $signed({2'b00, m_reg});
    assign de_move  = d_move <<< 1;
    assign de_place = -$signed({1'b0, m_reg, 1'b0});
    assign same_row = (tx_reg == ox_reg);

    always_comb
    begin
        if (d_move == 5'sd1)
        begin
            thr_sel = thr_two_reg;
        end
        else if (d_move == 5'sd2)
        begin
            thr_sel = thr_four_reg;
        end
        else
        begin
            thr_sel = thr_six_reg;
        end
        accept = (d_move <= 5'sd0) || (rnd_reg < thr_sel);
    end

    always_comb
    begin
        state_next      = state_reg;
        rd_step_next    = rd_step_reg;
        pend_vld_next   = 1'b0;
        rv_next         = rv_reg;
        count_next      = count_reg;
        energy_next     = energy_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        dir_next        = dir_reg;
        rnd_next        = rnd_reg;
        ox_next         = ox_reg;
        oy_next         = oy_reg;
        tx_next         = tx_reg;
        ty_next         = ty_reg;
        pend_step_next  = pend_step_reg;
        pend_rv_next    = pend_rv_reg;
        n_next          = n_reg;
        m_next          = m_reg;
        tocc_next       = tocc_reg;
        row_o_next      = row_o_reg;
        row_t_next      = row_t_reg;
        res_status_next = res_status_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        out_status_next = out_status_reg;
        out_energy_next = out_energy_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;

        occ_we    = 1'b0;
        occ_waddr = ox_reg;
        occ_wdata = '0;
        occ_re    = 1'b0;
        pos_we    = 1'b0;
        pos_waddr = idx_reg;
        pos_wdata = {tx_reg, ty_reg};
        pos_re    = 1'b0;
        pos_raddr = PW'(particle_index);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next = func;
                    idx_next  = PW'(particle_index);
                    dir_next  = direction;
                    rnd_next  = random_value;
                    n_next    = '0;
                    m_next    = '0;
                    if (func == FUNC_PLACE)
                    begin
                        res_x_next = site_x;
                        res_y_next = site_y;
                        if ((count_reg >= CW'(MAX_PARTICLES)) ||
                            (32'(site_x) >= 32'(SIDE_X)) ||
                            (32'(site_y) >= 32'(SIDE_Y)))
                        begin
                            res_status_next = STAT_INVALID;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            tx_next      = XW'(site_x);
                            ty_next      = YW'(site_y);
                            rd_step_next = STEP_T_ROW;
                            state_next   = S_SCAN;
                        end
                    end
                    else
                    begin
                        if (32'(particle_index) >= 32'(count_reg))
                        begin
                            res_status_next = STAT_INVALID;
                            res_x_next      = '0;
                            res_y_next      = '0;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            pos_re     = 1'b1;
                            state_next = S_FETCH;
                        end
                    end
                end
            end

            S_FETCH:
            begin
                ox_next    = pos_rdata[XW+YW-1:YW];
                oy_next    = pos_rdata[YW-1:0];
                tx_next    = pos_rdata[XW+YW-1:YW];
                ty_next    = pos_rdata[YW-1:0];
                res_x_next = 6'(pos_rdata[XW+YW-1:YW]);
                res_y_next = 6'(pos_rdata[YW-1:0]);
                case (dir_reg)
                    DIR_XP:  tx_next = inc_x(pos_rdata[XW+YW-1:YW]);
                    DIR_XM:  tx_next = dec_x(pos_rdata[XW+YW-1:YW]);
                    DIR_YP:  ty_next = inc_y(pos_rdata[YW-1:0]);
                    DIR_YM:  ty_next = dec_y(pos_rdata[YW-1:0]);
                    default: ;
                endcase
                rd_step_next = STEP_O_ROW;
                state_next   = S_SCAN;
            end

            S_SCAN:
            begin
                if (rd_step_reg <= STEP_T_HI)
                begin
                    occ_re         = 1'b1;
                    pend_vld_next  = 1'b1;
                    pend_step_next = rd_step_reg;
                    pend_rv_next   = rv_reg[occ_raddr];
                    rd_step_next   = rd_step_reg + 3'd1;
                end
                if (pend_vld_reg)
                begin
                    case (pend_step_reg)
                        STEP_O_ROW:
                        begin
                            n_next     = n_reg + 3'(tally.cnt);
                            row_o_next = occ_row;
                        end
                        STEP_O_LO, STEP_O_HI:
                        begin
                            n_next = n_reg + 3'(tally.cnt);
                        end
                        STEP_T_ROW:
                        begin
                            m_next     = m_reg + 3'(tally.cnt);
                            tocc_next  = tally.ctr;
                            row_t_next = occ_row;
                        end
                        STEP_T_LO, STEP_T_HI:
                        begin
                            m_next = m_reg + 3'(tally.cnt);
                        end
                        default: ;
                    endcase
                    if (pend_step_reg == STEP_T_HI)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                if (tocc_reg)
                begin
                    res_status_next = STAT_OCCUPIED;
                end
                else if (func_reg == FUNC_PLACE)
                begin
                    occ_we           = 1'b1;
                    occ_waddr        = tx_reg;
                    occ_wdata        = row_t_reg | col_bit(ty_reg);
                    rv_next[tx_reg]  = 1'b1;
                    pos_we           = 1'b1;
                    pos_waddr        = PW'(count_reg);
                    count_next       = count_reg + CW'(1);
                    energy_next      = sat_add(energy_reg, de_place);
                    res_status_next  = STAT_OK;
                end
                else if (accept)
                begin
                    pos_we          = 1'b1;
                    occ_we          = 1'b1;
                    occ_waddr       = ox_reg;
                    occ_wdata       = (row_o_reg & ~col_bit(oy_reg)) |
                                      (same_row ? col_bit(ty_reg) : '0);
                    rv_next[ox_reg] = 1'b1;
                    energy_next     = sat_add(energy_reg, de_move);
                    res_status_next = STAT_OK;
                    res_x_next      = 6'(tx_reg);
                    res_y_next      = 6'(ty_reg);
                    if (!same_row)
                    begin
                        state_next = S_WRITE;
                    end
                end
                else
                begin
                    res_status_next = STAT_REJECT;
                end
            end

            S_WRITE:
            begin
                occ_we          = 1'b1;
                occ_waddr       = tx_reg;
                occ_wdata       = row_t_reg | col_bit(ty_reg);
                rv_next[tx_reg] = 1'b1;
                state_next      = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_energy_next = energy_reg;
                    out_x_next      = res_x_reg;
                    out_y_next      = res_y_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_step_reg   <= STEP_O_ROW;
            pend_vld_reg  <= 1'b0;
            rv_reg        <= '0;
            count_reg     <= '0;
            energy_reg    <= '0;
            thr_two_reg   <= RISE_TWO_RST;
            thr_four_reg  <= RISE_FOUR_RST;
            thr_six_reg   <= RISE_SIX_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_step_reg   <= rd_step_next;
            pend_vld_reg  <= pend_vld_next;
            rv_reg        <= rv_next;
            count_reg     <= count_next;
            energy_reg    <= energy_next;
            thr_two_reg   <= thr_two_next;
            thr_four_reg  <= thr_four_next;
            thr_six_reg   <= thr_six_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        dir_reg        <= dir_next;
        rnd_reg        <= rnd_next;
        ox_reg         <= ox_next;
        oy_reg         <= oy_next;
        tx_reg         <= tx_next;
        ty_reg         <= ty_next;
        pend_step_reg  <= pend_step_next;
        pend_rv_reg    <= pend_rv_next;
        n_reg          <= n_next;
        m_reg          <= m_next;
        tocc_reg       <= tocc_next;
        row_o_reg      <= row_o_next;
        row_t_reg      <= row_t_next;
        res_status_reg <= res_status_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        out_status_reg <= out_status_next;
        out_energy_reg <= out_energy_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
    end

endmodule

// ===== dv/lattice_gas_kawasaki_move_core_test.sv =====
// Self-checking testbench for lattice_gas_kawasaki_move_core: place and hop words
// are checked against a lattice tracker class, and thresholds are swept over APB.
// Depends on lgk_pkg and the lattice_gas_kawasaki_move_core RTL.
`timescale 1ns / 1ps

module lattice_gas_kawasaki_move_core_test;
    import lgk_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [13:0] energy;
        logic [5:0]         pos_x;
        logic [5:0]         pos_y;
    } hop_result_t;

    class lattice_tracker;
        bit          occupied [SIDE_X_DEF][SIDE_Y_DEF];
        logic [5:0]  spot_x [MAX_PARTICLES_DEF];
        logic [5:0]  spot_y [MAX_PARTICLES_DEF];
        int          population;
        int          energy_j;
        logic [31:0] rise_thresh [3];
        hop_result_t pending_results [$];
        int          fail_count;
        int          status_tally [4];
        int          uphill_count;
        int          place_count;
        int          hop_count;

        function new();
            population = 0;
            energy_j   = 0;
            fail_count = 0;
            rise_thresh[REG_RISE_TWO]  = RISE_TWO_RST;
            rise_thresh[REG_RISE_FOUR] = RISE_FOUR_RST;
            rise_thresh[REG_RISE_SIX]  = RISE_SIX_RST;
        endfunction

        function int neighbours(int x, int y);
            return int'(occupied[(x + 1) % SIDE_X_DEF][y])
                 + int'(occupied[(x + SIDE_X_DEF - 1) % SIDE_X_DEF][y])
                 + int'(occupied[x][(y + 1) % SIDE_Y_DEF])
                 + int'(occupied[x][(y + SIDE_Y_DEF - 1) % SIDE_Y_DEF]);
        endfunction

        function void shift_energy(int d);
            energy_j = energy_j + d;
            if (energy_j < -8192)
            begin
                energy_j = -8192;
            end
            if (energy_j > 8191)
            begin
                energy_j = 8191;
            end
        endfunction

        function void note_word(logic f, logic [5:0] sx, logic [5:0] sy, logic [9:0] idx,
                                logic [1:0] dir, logic [31:0] rnd);
            hop_result_t r;
            int          ox, oy, tx, ty, de;
            logic        take;
            r.pos_x = '0;
            r.pos_y = '0;
            if (f == FUNC_PLACE)
            begin
                place_count++;
                r.pos_x = sx;
                r.pos_y = sy;
                if (population >= MAX_PARTICLES_DEF || sx >= SIDE_X_DEF || sy >= SIDE_Y_DEF)
                begin
                    r.status = STAT_INVALID;
                end
                else if (occupied[sx][sy])
                begin
                    r.status = STAT_OCCUPIED;
                end
                else
                begin
                    occupied[sx][sy]   = 1'b1;
                    spot_x[population] = sx;
                    spot_y[population] = sy;
                    population++;
                    shift_energy(-2 * neighbours(int'(sx), int'(sy)));
                    r.status = STAT_OK;
                end
            end
            else if (idx >= population)
            begin
                hop_count++;
                r.status = STAT_INVALID;
            end
            else
            begin
                hop_count++;
                ox = int'(spot_x[idx]);
                oy = int'(spot_y[idx]);
                tx = ox;
                ty = oy;
                case (dir)
                    DIR_XP:  tx = (ox + 1) % SIDE_X_DEF;
                    DIR_XM:  tx = (ox + SIDE_X_DEF - 1) % SIDE_X_DEF;
                    DIR_YP:  ty = (oy + 1) % SIDE_Y_DEF;
                    default: ty = (oy + SIDE_Y_DEF - 1) % SIDE_Y_DEF;
                endcase
                r.pos_x = 6'(ox);
                r.pos_y = 6'(oy);
                if (occupied[tx][ty])
                begin
                    r.status = STAT_OCCUPIED;
                end
                else
                begin
                    // old site counts as a neighbour of the target, so drop it
                    de = 2 * (neighbours(ox, oy) - (neighbours(tx, ty) - 1));
                    if (de <= 0)
                        take = 1'b1;
                    else if (de == 2)
                        take = rnd < rise_thresh[REG_RISE_TWO];
                    else if (de == 4)
                        take = rnd < rise_thresh[REG_RISE_FOUR];
                    else
                        take = rnd < rise_thresh[REG_RISE_SIX];
                    if (take)
                    begin
                        occupied[ox][oy] = 1'b0;
                        occupied[tx][ty] = 1'b1;
                        spot_x[idx] = 6'(tx);
                        spot_y[idx] = 6'(ty);
                        shift_energy(de);
                        r.pos_x  = 6'(tx);
                        r.pos_y  = 6'(ty);
                        r.status = STAT_OK;
                        if (de > 0)
                            uphill_count++;
                    end
                    else
                    begin
                        r.status = STAT_REJECT;
                    end
                end
            end
            r.energy = 14'(energy_j);
            status_tally[r.status]++;
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [1:0] got_status, logic signed [13:0] got_energy,
                                 logic [5:0] got_x, logic [5:0] got_y);
            hop_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing pending");
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                fail_count++;
            end
            if (got_energy !== want.energy)
            begin
                $error("energy: expected %0d, got %0d", want.energy, got_energy);
                fail_count++;
            end
            if (got_x !== want.pos_x)
            begin
                $error("pos_x: expected %0d, got %0d", want.pos_x, got_x);
                fail_count++;
            end
            if (got_y !== want.pos_y)
            begin
                $error("pos_y: expected %0d, got %0d", want.pos_y, got_y);
                fail_count++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               func = FUNC_PLACE;
    logic [5:0]         site_x = '0;
    logic [5:0]         site_y = '0;
    logic [9:0]         particle_index = '0;
    logic [1:0]         direction = DIR_XP;
    logic [31:0]        random_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic signed [13:0] energy;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;

    int             tx_idle_pct = 12;
    int             rx_idle_pct = 62;
    lattice_tracker lattice = new();

    lattice_gas_kawasaki_move_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .site_x         (site_x),
        .site_y         (site_y),
        .particle_index (particle_index),
        .direction      (direction),
        .random_value   (random_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .status         (status),
        .energy         (energy),
        .pos_x          (pos_x),
        .pos_y          (pos_y)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                lattice.check_word(status, energy, pos_x, pos_y);
            end
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial
    begin
        #20_000_000;
        $display("lattice_gas_kawasaki_move_core verification failed");
        $finish;
    end

    task automatic send_word(input logic f, input logic [5:0] sx, input logic [5:0] sy,
                             input logic [9:0] idx, input logic [1:0] dir,
                             input logic [31:0] rnd);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        func           <= f;
        site_x         <= sx;
        site_y         <= sy;
        particle_index <= idx;
        direction      <= dir;
        random_value   <= rnd;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        lattice.note_word(f, sx, sy, idx, dir, rnd);
    endtask

    task automatic place_at(input logic [5:0] sx, input logic [5:0] sy);
        send_word(FUNC_PLACE, sx, sy, 10'($urandom), 2'($urandom), $urandom);
    endtask

    task automatic hop(input logic [9:0] idx, input logic [1:0] dir, input logic [31:0] rnd);
        send_word(FUNC_MOVE, 6'($urandom), 6'($urandom), idx, dir, rnd);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (lattice.pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic program_threshold(input logic [1:0] reg_sel, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("prdata: expected %0d, got %0d", value, prdata);
            lattice.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        lattice.rise_thresh[reg_sel] = value;
        @(posedge clk);
    endtask

    task automatic set_thresholds(input logic [31:0] two, input logic [31:0] four,
                                  input logic [31:0] six);
        drain_results();
        program_threshold(REG_RISE_TWO, two);
        program_threshold(REG_RISE_FOUR, four);
        program_threshold(REG_RISE_SIX, six);
    endtask

    // mostly hops of listed particles, a quarter places, some next to the cluster
    task automatic run_random(input int n_words);
        int          pick;
        int          k;
        logic        f;
        logic [5:0]  sx, sy;
        logic [9:0]  idx;
        logic [1:0]  dir;
        logic [31:0] rnd;
        repeat (n_words)
        begin
            pick = $urandom_range(0, 99);
            sx   = 6'($urandom);
            sy   = 6'($urandom);
            idx  = 10'($urandom);
            dir  = 2'($urandom);
            rnd  = $urandom >> $urandom_range(0, 31);
            if (pick < 25 || lattice.population == 0)
            begin
                f = FUNC_PLACE;
                if (pick < 12 && lattice.population != 0)
                begin
                    k  = $urandom_range(0, lattice.population - 1);
                    sx = lattice.spot_x[k] + 6'($urandom_range(0, 2)) - 6'd1;
                    sy = lattice.spot_y[k] + 6'($urandom_range(0, 2)) - 6'd1;
                end
            end
            else
            begin
                f = FUNC_MOVE;
                if (pick < 92)
                begin
                    idx = 10'($urandom_range(0, lattice.population - 1));
                end
            end
            send_word(f, sx, sy, idx, dir, rnd);
        end
    endtask

    initial
    begin
        logic [5:0] fx, fy;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corner cluster across both wrap seams, then uphill steps 2 and 6 at threshold
        place_at(6'd0, 6'd0);
        place_at(6'd63, 6'd63);
        place_at(6'd0, 6'd0);
        hop(10'd1023, DIR_XP, 32'd0);
        hop(10'd2, DIR_YM, 32'd0);
        place_at(6'd63, 6'd0);
        hop(10'd2, DIR_XM, 32'hFFFF_FFFF);
        hop(10'd2, DIR_XM, 32'd0);
        hop(10'd2, DIR_XP, 32'hFFFF_FFFF);
        hop(10'd0, DIR_XM, 32'd0);
        place_at(6'd0, 6'd63);
        place_at(6'd1, 6'd0);
        hop(10'd0, DIR_YP, RISE_SIX_RST);
        hop(10'd0, DIR_YP, RISE_SIX_RST - 32'd1);
        hop(10'd0, DIR_YM, 32'hFFFF_FFFF);
        hop(10'd4, DIR_XP, RISE_TWO_RST);
        hop(10'd4, DIR_XP, RISE_TWO_RST - 32'd1);
        hop(10'd4, DIR_YP, 32'hFFFF_FFFF);

        set_thresholds(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(50);
        drain_results();
        run_random(50);

        tx_idle_pct = 62;
        rx_idle_pct = 12;
        set_thresholds(32'd0, 32'd0, 32'd0);
        run_random(100);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_thresholds($urandom >> 1, $urandom >> 4, $urandom >> 7);
        run_random(100);

        // fill the list to capacity, then keep going on a full list
        set_thresholds(RISE_TWO_RST, RISE_FOUR_RST, RISE_SIX_RST);
        while (lattice.population < MAX_PARTICLES_DEF)
        begin
            do
            begin
                fx = 6'($urandom);
                fy = 6'($urandom);
            end
            while (lattice.occupied[fx][fy]);
            place_at(fx, fy);
        end
        run_random(40);

        drain_results();
        repeat (16) @(posedge clk);

        $display("Summary: %0d place and %0d hop words; done %0d (uphill %0d), rejected %0d,",
                 lattice.place_count, lattice.hop_count, lattice.status_tally[STAT_OK],
                 lattice.uphill_count, lattice.status_tally[STAT_REJECT]);
        $display("Summary: blocked %0d, invalid or full %0d; %0d particles, final energy %0d",
                 lattice.status_tally[STAT_OCCUPIED], lattice.status_tally[STAT_INVALID],
                 lattice.population, lattice.energy_j);
        if (lattice.fail_count == 0 && lattice.pending_results.size() == 0)
        begin
            $display("lattice_gas_kawasaki_move_core verification clean");
        end
        else
        begin
            $display("lattice_gas_kawasaki_move_core verification failed");
        end
        $finish;
    end

endmodule
